// File: design/ecsm_pkg.sv
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared types and constants for the prime-field scalar multiply core.
// ----------------------------------------------------------------------------
`default_nettype none

package ecsm_pkg;

  localparam int FIELD_BITS_DEF  = 32;
  localparam int SCALAR_BITS_DEF = 40;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_X,
    ST_RED_Y,
    ST_BIT,
    ST_PADD,
    ST_YSUM,
    ST_XX,
    ST_X2,
    ST_X3,
    ST_NUM_T,
    ST_NUM_C,
    ST_DEN,
    ST_EU_CHK,
    ST_EU_DIV,
    ST_EU_MUL,
    ST_EU_SUB,
    ST_LAM,
    ST_LL,
    ST_L2,
    ST_L3,
    ST_Y1,
    ST_Y2,
    ST_Y3,
    ST_NEXT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// File: design/ecsm_alu.sv
// ----------------------------------------------------------------------------
// ecsm_alu
// Shared modular unit: add/sub mod p with a registered result, bit-serial multiply mod p,
// restoring divide giving quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsm_alu #(
  parameter int W = ecsm_pkg::FIELD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ecsm_pkg::alu_req_t req,
  input  wire logic [W-1:0]     opa,
  input  wire logic [W-1:0]     opb,
  input  wire logic [W-1:0]     p,
  output logic                  done,
  output logic [W-1:0]          res,
  output logic [W-1:0]          rem
);

  localparam int CW = $clog2(W + 1);

  logic                busy;
  ecsm_pkg::alu_op_t   op_q;
  logic [W-1:0]        x;
  logic [W-1:0]        y;
  logic [W-1:0]        acc;
  logic [CW-1:0]       cnt;

  logic [W:0]          rem2;
  logic                take;
  logic [W-1:0]        rem_next;
  logic [W-1:0]        quo_next;

  function automatic logic [W-1:0] fadd(input logic [W-1:0] u, input logic [W-1:0] v,
                                        input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, u} + {1'b0, v};
    fadd = (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] fsub(input logic [W-1:0] u, input logic [W-1:0] v,
                                        input logic [W-1:0] m);
    fsub = (u >= v) ? (u - v) : (u + (m - v));
  endfunction

  // one restoring division step
  always_comb begin
    rem2     = {acc, x[W-1]};
    take     = (rem2 >= {1'b0, y});
    rem_next = take ? W'(rem2 - {1'b0, y}) : rem2[W-1:0];
    quo_next = {x[W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op_q <= req.op;
        case (req.op)
          ecsm_pkg::ALU_ADD: begin
            res  <= fadd(opa, opb, p);
            done <= 1'b1;
          end
          ecsm_pkg::ALU_SUB: begin
            res  <= fsub(opa, opb, p);
            done <= 1'b1;
          end
          ecsm_pkg::ALU_MUL: begin
            busy <= 1'b1;
            acc  <= '0;
            x    <= opa;
            y    <= opb;
          end
          ecsm_pkg::ALU_DIV: begin
            busy <= 1'b1;
            acc  <= '0;
            x    <= opa;
            y    <= opb;
            cnt  <= CW'(W);
          end
          default: done <= 1'b1;
        endcase
      end else if (busy) begin
        case (op_q)
          ecsm_pkg::ALU_MUL: begin
            if (y == '0) begin
              res  <= acc;
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              if (y[0]) acc <= fadd(acc, x, p);
              x <= fadd(x, x, p);
              y <= y >> 1;
            end
          end
          ecsm_pkg::ALU_DIV: begin
            acc <= rem_next;
            x   <= quo_next;
            cnt <= cnt - 1'b1;
            if (cnt == CW'(1)) begin
              res  <= quo_next;
              rem  <= rem_next;
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: design/ec_scalar_multiply_prime_field_core.sv
// Per request: input reduction of curve_a, x and y (none when modulus is below 2), then per
//   scalar bit one doubling and, for a set bit, one addition; an inversion in a point
//   operation takes up to about 1.44*W extended Euclid rounds.
// Throughput: one request at a time; a finished result may wait while the next is taken.
// All field arithmetic but the quotient reduction (qred) runs through the single shared modular unit (ecsm_alu).
// Reset: synchronous, clears control state and sets modulus to 3, curve_a to 0.
// ----------------------------------------------------------------------------
// ec_scalar_multiply_prime_field_core
// MSB-first double-and-add scalar multiply on y^2 = x^3 + ax + b mod p.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_scalar_multiply_prime_field_core #(
  parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
  parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FIELD_BITS-1:0]          cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [FIELD_BITS-1:0]          base_x,
  input  wire logic [FIELD_BITS-1:0]          base_y,
  input  wire logic [SCALAR_BITS-1:0]         scalar,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [FIELD_BITS-1:0]               result_x,
  output logic [FIELD_BITS-1:0]               result_y,
  output logic                                result_infinity
);

  localparam int W     = FIELD_BITS;
  localparam int CNT_W = $clog2(SCALAR_BITS + 1);

  ecsm_pkg::state_t state, state_next;

  logic [W-1:0] modulus, curve_a;
  logic [W-1:0] a_red, bx, by;
  logic [SCALAR_BITS-1:0] k;
  logic [CNT_W-1:0] cnt;
  logic         dbl;
  logic [W-1:0] ax, ay;
  logic         ainf;
  logic [W-1:0] xx, num, lam, x3;
  logic [W-1:0] r0, r1, t0, t1;

  ecsm_pkg::alu_req_t alu_req;
  logic [W-1:0] opa, opb;
  logic         alu_done;
  logic [W-1:0] alu_res, alu_rem;

  logic [W-1:0] tx, ty;
  logic [W-1:0] qred;
  logic         accept;
  logic         fin;
  logic [W-1:0] fin_x, fin_y;
  logic         fin_inf;
  logic         out_load;

  assign accept = in_valid && in_ready;
  assign tx     = dbl ? ax : bx;
  assign ty     = dbl ? ay : by;
  assign qred   = (alu_res >= modulus) ? (alu_res - modulus) : alu_res;

  ecsm_alu #(.W(W)) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .opa  (opa),
    .opb  (opb),
    .p    (modulus),
    .done (alu_done),
    .res  (alu_res),
    .rem  (alu_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ecsm_pkg::ST_IDLE:
        if (accept) state_next = (modulus < W'(2)) ? ecsm_pkg::ST_OUT : ecsm_pkg::ST_RED_A;
      ecsm_pkg::ST_RED_A: if (alu_done) state_next = ecsm_pkg::ST_RED_X;
      ecsm_pkg::ST_RED_X: if (alu_done) state_next = ecsm_pkg::ST_RED_Y;
      ecsm_pkg::ST_RED_Y: if (alu_done) state_next = ecsm_pkg::ST_BIT;
      ecsm_pkg::ST_BIT:
        state_next = (cnt == '0) ? ecsm_pkg::ST_OUT : ecsm_pkg::ST_PADD;
      ecsm_pkg::ST_PADD: begin
        if (ainf) state_next = ecsm_pkg::ST_NEXT;
        else if (ax == tx) state_next = ecsm_pkg::ST_YSUM;
        else state_next = ecsm_pkg::ST_NUM_C;
      end
      ecsm_pkg::ST_YSUM:
        if (alu_done) state_next = (alu_res == '0) ? ecsm_pkg::ST_NEXT : ecsm_pkg::ST_XX;
      ecsm_pkg::ST_XX:    if (alu_done) state_next = ecsm_pkg::ST_X2;
      ecsm_pkg::ST_X2:    if (alu_done) state_next = ecsm_pkg::ST_X3;
      ecsm_pkg::ST_X3:    if (alu_done) state_next = ecsm_pkg::ST_NUM_T;
      ecsm_pkg::ST_NUM_T: if (alu_done) state_next = ecsm_pkg::ST_DEN;
      ecsm_pkg::ST_NUM_C: if (alu_done) state_next = ecsm_pkg::ST_DEN;
      ecsm_pkg::ST_DEN:   if (alu_done) state_next = ecsm_pkg::ST_EU_CHK;
      ecsm_pkg::ST_EU_CHK: begin
        if (r1 != '0) state_next = ecsm_pkg::ST_EU_DIV;
        else if (r0 != W'(1)) state_next = ecsm_pkg::ST_NEXT;
        else state_next = ecsm_pkg::ST_LAM;
      end
      ecsm_pkg::ST_EU_DIV: if (alu_done) state_next = ecsm_pkg::ST_EU_MUL;
      ecsm_pkg::ST_EU_MUL: if (alu_done) state_next = ecsm_pkg::ST_EU_SUB;
      ecsm_pkg::ST_EU_SUB: if (alu_done) state_next = ecsm_pkg::ST_EU_CHK;
      ecsm_pkg::ST_LAM:    if (alu_done) state_next = ecsm_pkg::ST_LL;
      ecsm_pkg::ST_LL:     if (alu_done) state_next = ecsm_pkg::ST_L2;
      ecsm_pkg::ST_L2:     if (alu_done) state_next = ecsm_pkg::ST_L3;
      ecsm_pkg::ST_L3:     if (alu_done) state_next = ecsm_pkg::ST_Y1;
      ecsm_pkg::ST_Y1:     if (alu_done) state_next = ecsm_pkg::ST_Y2;
      ecsm_pkg::ST_Y2:     if (alu_done) state_next = ecsm_pkg::ST_Y3;
      ecsm_pkg::ST_Y3:     if (alu_done) state_next = ecsm_pkg::ST_NEXT;
      ecsm_pkg::ST_NEXT:
        state_next = (dbl && k[SCALAR_BITS-1]) ? ecsm_pkg::ST_PADD : ecsm_pkg::ST_BIT;
      ecsm_pkg::ST_OUT:
        if (!out_valid || out_ready) state_next = ecsm_pkg::ST_IDLE;
      default: state_next = ecsm_pkg::ST_IDLE;
    endcase
  end

  // unit requests and point-operation results
  always_comb begin
    alu_req  = '{start: 1'b0, op: ecsm_pkg::ALU_ADD};
    opa      = '0;
    opb      = '0;
    in_ready = 1'b0;
    fin      = 1'b0;
    fin_x    = '0;
    fin_y    = '0;
    fin_inf  = 1'b1;
    out_load = 1'b0;
    case (state)
      ecsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && (modulus >= W'(2))) begin
          alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_DIV};
          opa = curve_a; opb = modulus;
        end
      end
      ecsm_pkg::ST_RED_A: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_DIV};
        opa = bx; opb = modulus;
      end
      ecsm_pkg::ST_RED_X: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_DIV};
        opa = by; opb = modulus;
      end
      ecsm_pkg::ST_PADD: begin
        if (ainf) begin
          // doubling infinity stays at infinity; adding the base to infinity gives the base
          fin = 1'b1; fin_x = tx; fin_y = ty; fin_inf = dbl;
        end else if (ax == tx) begin
          alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_ADD};
          opa = ay; opb = ty;
        end else begin
          alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_SUB};
          opa = ty; opb = ay;
        end
      end
      ecsm_pkg::ST_YSUM: if (alu_done) begin
        if (alu_res == '0) fin = 1'b1;
        else begin
          alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_MUL};
          opa = ax; opb = ax;
        end
      end
      ecsm_pkg::ST_XX: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_ADD};
        opa = alu_res; opb = alu_res;
      end
      ecsm_pkg::ST_X2: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_ADD};
        opa = alu_res; opb = xx;
      end
      ecsm_pkg::ST_X3: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_ADD};
        opa = alu_res; opb = a_red;
      end
      ecsm_pkg::ST_NUM_T: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_ADD};
        opa = ay; opb = ay;
      end
      ecsm_pkg::ST_NUM_C: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_SUB};
        opa = tx; opb = ax;
      end
      ecsm_pkg::ST_EU_CHK: begin
        if (r1 != '0) begin
          alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_DIV};
          opa = r0; opb = r1;
        end else if (r0 != W'(1)) begin
          fin = 1'b1;
        end else begin
          alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_MUL};
          opa = num; opb = t0;
        end
      end
      ecsm_pkg::ST_EU_DIV: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_MUL};
        opa = qred; opb = t1;
      end
      ecsm_pkg::ST_EU_MUL: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_SUB};
        opa = t0; opb = alu_res;
      end
      ecsm_pkg::ST_LAM: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_MUL};
        opa = alu_res; opb = alu_res;
      end
      ecsm_pkg::ST_LL: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_SUB};
        opa = alu_res; opb = ax;
      end
      ecsm_pkg::ST_L2: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_SUB};
        opa = alu_res; opb = tx;
      end
      ecsm_pkg::ST_L3: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_SUB};
        opa = ax; opb = alu_res;
      end
      ecsm_pkg::ST_Y1: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_MUL};
        opa = lam; opb = alu_res;
      end
      ecsm_pkg::ST_Y2: if (alu_done) begin
        alu_req = '{start: 1'b1, op: ecsm_pkg::ALU_SUB};
        opa = alu_res; opb = ay;
      end
      ecsm_pkg::ST_Y3: if (alu_done) begin
        fin = 1'b1; fin_x = x3; fin_y = alu_res; fin_inf = 1'b0;
      end
      ecsm_pkg::ST_OUT: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ecsm_pkg::ST_IDLE;
      modulus   <= W'(3);
      curve_a   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          ecsm_pkg::CFG_MODULUS: modulus <= cfg_data;
          ecsm_pkg::CFG_CURVE_A: curve_a <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      bx   <= base_x;
      by   <= base_y;
      k    <= scalar;
      cnt  <= CNT_W'(SCALAR_BITS);
      ainf <= 1'b1;
      ax   <= '0;
      ay   <= '0;
    end
    if (fin) begin
      ax   <= fin_x;
      ay   <= fin_y;
      ainf <= fin_inf;
    end
    if (out_load) begin
      result_x        <= ainf ? '0 : ax;
      result_y        <= ainf ? '0 : ay;
      result_infinity <= ainf;
    end
    case (state)
      ecsm_pkg::ST_RED_A: if (alu_done) a_red <= alu_rem;
      ecsm_pkg::ST_RED_X: if (alu_done) bx <= alu_rem;
      ecsm_pkg::ST_RED_Y: if (alu_done) by <= alu_rem;
      ecsm_pkg::ST_BIT:   if (cnt != '0) dbl <= 1'b1;
      ecsm_pkg::ST_XX:    if (alu_done) xx <= alu_res;
      ecsm_pkg::ST_NUM_T: if (alu_done) num <= alu_res;
      ecsm_pkg::ST_NUM_C: if (alu_done) num <= alu_res;
      ecsm_pkg::ST_DEN: if (alu_done) begin
        r0 <= modulus;
        r1 <= alu_res;
        t0 <= '0;
        t1 <= W'(1);
      end
      ecsm_pkg::ST_EU_DIV: if (alu_done) begin
        r0 <= r1;
        r1 <= alu_rem;
      end
      ecsm_pkg::ST_EU_SUB: if (alu_done) begin
        t0 <= t1;
        t1 <= alu_res;
      end
      ecsm_pkg::ST_LAM: if (alu_done) lam <= alu_res;
      ecsm_pkg::ST_L3:  if (alu_done) x3 <= alu_res;
      ecsm_pkg::ST_NEXT: begin
        if (dbl && k[SCALAR_BITS-1]) dbl <= 1'b0;
        else begin
          k   <= k << 1;
          cnt <= cnt - 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: design/ecsm_checker.sv
// ----------------------------------------------------------------------------
// ecsm_checker
// Port-level checks for the scalar multiply core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsm_checker #(
  parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [FIELD_BITS-1:0]   result_x,
  input wire logic [FIELD_BITS-1:0]   result_y,
  input wire logic                    result_infinity
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_x) && $stable(result_y)
      && $stable(result_infinity))
    else $error("result changed while stalled");

  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_infinity |-> result_x == '0 && result_y == '0)
    else $error("infinity result with non-zero coordinates");

  // one request at a time: busy straight after a take
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ec_scalar_multiply_prime_field_core ecsm_checker #(
  .FIELD_BITS  (FIELD_BITS)
) u_ecsm_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .result_x        (result_x),
  .result_y        (result_y),
  .result_infinity (result_infinity)
);

`default_nettype wire

// File: test/tb_ec_scalar_multiply_prime_field_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ec_scalar_multiply_prime_field_core
// Drives point/scalar requests through the core under random idling on both
// channels and checks every result against a behavioural scalar multiply
// kept in the bench, across several modulus and curve_a settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ec_scalar_multiply_prime_field_core;

  localparam int FW = 32;
  localparam int SW = 40;

  typedef struct {
    logic [FW-1:0] x;
    logic [FW-1:0] y;
    logic [SW-1:0] k;
  } point_req_t;

  typedef struct {
    logic [FW-1:0] x;
    logic [FW-1:0] y;
    logic          inf;
  } curve_point_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_write = 1'b0;
  logic          cfg_index = 1'b0;
  logic [FW-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [FW-1:0] base_x = '0;
  logic [FW-1:0] base_y = '0;
  logic [SW-1:0] scalar = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [FW-1:0] result_x;
  logic [FW-1:0] result_y;
  logic          result_infinity;

  ec_scalar_multiply_prime_field_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .base_x(base_x), .base_y(base_y), .scalar(scalar),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_x(result_x), .result_y(result_y), .result_infinity(result_infinity)
  );

  point_req_t   pending_reqs[$];
  curve_point_t expected_points[$];
  longint unsigned field_p = 3;
  longint unsigned field_a = 0;
  int errors = 0;
  int send_gap = 0;
  int recv_stall = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---- behavioural model ----
  function automatic longint unsigned mod_mul(longint unsigned u, longint unsigned v,
                                              longint unsigned p);
    return (u * v) % p;
  endfunction

  function automatic longint unsigned mod_sub(longint unsigned u, longint unsigned v,
                                              longint unsigned p);
    return (u >= v) ? u - v : u + (p - v);
  endfunction

  // extended Euclid; ok clears when no inverse exists
  function automatic longint unsigned mod_inverse(longint unsigned u, longint unsigned p,
                                                  output bit ok);
    longint unsigned r0, r1, r2, t0, t1, t2, q;
    r0 = p; r1 = u; t0 = 0; t1 = 1 % p;
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      t2 = mod_sub(t0, mod_mul(q % p, t1, p), p);
      r0 = r1; r1 = r2;
      t0 = t1; t1 = t2;
    end
    ok = (r0 == 1);
    return t0;
  endfunction

  function automatic curve_point_t point_add(curve_point_t s, curve_point_t t,
                                             longint unsigned p, longint unsigned a);
    curve_point_t r;
    longint unsigned sx, sy, tx, ty, num, den, inv, lam, x3, xx;
    bit ok;
    r = '{x: '0, y: '0, inf: 1'b1};
    if (s.inf) return t;
    if (t.inf) return s;
    sx = 64'(s.x); sy = 64'(s.y); tx = 64'(t.x); ty = 64'(t.y);
    if (sx == tx && (sy + ty) % p == 0) return r;
    if (sx == tx) begin
      xx  = mod_mul(sx, sx, p);
      num = (3 * xx + a) % p;
      den = (2 * sy) % p;
    end else begin
      num = mod_sub(ty, sy, p);
      den = mod_sub(tx, sx, p);
    end
    inv = mod_inverse(den, p, ok);
    if (!ok) return r;
    lam = mod_mul(num, inv, p);
    x3  = mod_sub(mod_sub(mod_mul(lam, lam, p), sx, p), tx, p);
    r.x = x3[FW-1:0];
    r.y = FW'(mod_sub(mod_mul(lam, mod_sub(sx, x3, p), p), sy, p));
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic curve_point_t scalar_multiple(point_req_t q);
    curve_point_t acc, base;
    longint unsigned a;
    acc = '{x: '0, y: '0, inf: 1'b1};
    if (field_p >= 2) begin
      a = field_a % field_p;
      base.x = FW'(64'(q.x) % field_p);
      base.y = FW'(64'(q.y) % field_p);
      base.inf = 1'b0;
      for (int i = SW - 1; i >= 0; i--) begin
        acc = point_add(acc, acc, field_p, a);
        if (q.k[i]) acc = point_add(acc, base, field_p, a);
      end
    end
    if (acc.inf) begin
      acc.x = '0;
      acc.y = '0;
    end
    return acc;
  endfunction

  // ---- request driver ----
  always @(posedge clk) begin
    logic nxt_valid;
    point_req_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        expected_points.push_back(scalar_multiple('{x: base_x, y: base_y, k: scalar}));
        nxt_valid = 1'b0;
        send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          item = pending_reqs.pop_front();
          base_x <= item.x;
          base_y <= item.y;
          scalar <= item.k;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // ---- result monitor ----
  always @(posedge clk) begin
    curve_point_t exp_pt;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result x=%h y=%h inf=%b",
                                     result_x, result_y, result_infinity);
        end else begin
          exp_pt = expected_points.pop_front();
          if (result_x !== exp_pt.x || result_y !== exp_pt.y ||
              result_infinity !== exp_pt.inf) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected x=%h y=%h inf=%b, got x=%h y=%h inf=%b",
                       exp_pt.x, exp_pt.y, exp_pt.inf, result_x, result_y, result_infinity);
          end
        end
        recv_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (recv_stall > 0) recv_stall--;
      out_ready <= (recv_stall == 0);
    end
  end

  // ---- stimulus ----
  task automatic queue_req(logic [FW-1:0] x, logic [FW-1:0] y, logic [SW-1:0] k);
    pending_reqs.push_back('{x: x, y: y, k: k});
  endtask

  // hold until every request is taken and every result has returned
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [FW-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == ecsm_pkg::CFG_MODULUS) field_p = 64'(value);
    else field_a = 64'(value);
  endtask

  task automatic random_reqs(int n);
    logic [SW-1:0] k;
    for (int i = 0; i < n; i++) begin
      // keep most scalars short; a few span every scalar bit
      if ($urandom_range(0, 9) == 0) k = SW'({$urandom, $urandom});
      else k = SW'($urandom_range(0, 1023));
      queue_req($urandom, $urandom, k);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: modulus 3, a 0
    queue_req(32'd0, 32'd0, 40'd0);
    queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    queue_req(32'd1, 32'd1, 40'd5);
    queue_req(32'd2, 32'd0, 40'd2);
    drain();

    write_reg(ecsm_pkg::CFG_MODULUS, 32'd97);
    write_reg(ecsm_pkg::CFG_CURVE_A, 32'd2);
    queue_req(32'd3, 32'd6, 40'd0);
    queue_req(32'd3, 32'd6, 40'd1);
    queue_req(32'd3, 32'd6, 40'd2);
    queue_req(32'd3, 32'd6, 40'd3);
    queue_req(32'd5, 32'd0, 40'd2);         // tangent with zero y
    queue_req(32'd100, 32'd103, 40'd7);     // coordinates above modulus
    queue_req(32'hFFFF_FFFF, 32'd0, 40'd1);
    queue_req(32'd0, 32'hFFFF_FFFF, 40'h80_0000_0000);
    queue_req(32'd17, 32'd10, 40'hFF_FFFF_FFFF);
    queue_req(32'd17, 32'd10, 40'h55_AAAA_5555);
    drain();

    write_reg(ecsm_pkg::CFG_MODULUS, 32'd15);         // not prime: some inverses fail
    write_reg(ecsm_pkg::CFG_CURVE_A, 32'hFFFF_FFFF);
    queue_req(32'd3, 32'd5, 40'd2);
    queue_req(32'd4, 32'd6, 40'd9);
    random_reqs(10);
    drain();

    write_reg(ecsm_pkg::CFG_MODULUS, 32'd7);
    write_reg(ecsm_pkg::CFG_CURVE_A, 32'd3);
    random_reqs(25);
    drain();

    write_reg(ecsm_pkg::CFG_MODULUS, 32'd4294967291);
    write_reg(ecsm_pkg::CFG_CURVE_A, 32'd4294967290);
    random_reqs(15);
    drain();

    write_reg(ecsm_pkg::CFG_MODULUS, 32'hFFFF_FFFF);
    write_reg(ecsm_pkg::CFG_CURVE_A, 32'd0);
    random_reqs(10);
    drain();

    write_reg(ecsm_pkg::CFG_MODULUS, 32'd65521);
    write_reg(ecsm_pkg::CFG_CURVE_A, 32'd12345);
    random_reqs(15);
    drain();

    write_reg(ecsm_pkg::CFG_MODULUS, 32'd3);
    random_reqs(10);
    drain();

    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
